/* rtl/core/gls_pkg.sv */
// ----------------------------------------------------------------------------
// gls_pkg
// Shared types and constants of the grid line-of-sight block.
// ----------------------------------------------------------------------------
package gls_pkg;

	localparam int XW = 6;                  // column field width
	localparam int YW = 5;                  // row field width
	localparam int RW = 6;                  // sight radius width

	localparam int MAP_WIDTH_DEF  = 64;
	localparam int MAP_HEIGHT_DEF = 32;

	localparam logic [RW-1:0] RADIUS_RST = RW'(5);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef logic [RW-1:0] radius_t;

	typedef struct packed {
		logic          func;
		logic [XW-1:0] cell_x;
		logic [YW-1:0] cell_y;
		logic          cell_wall;
		logic          cell_lit;
		logic [XW-1:0] from_x;
		logic [YW-1:0] from_y;
		logic [XW-1:0] to_x;
		logic [YW-1:0] to_y;
		logic          darksight;
	} req_t;

	typedef struct packed {
		logic visible;
		logic line_clear;
		logic within_radius;
	} rsp_t;

endpackage

/* rtl/core/gls_chan_if.sv */
// ----------------------------------------------------------------------------
// gls_chan_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface gls_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/grid_line_of_sight_top.sv */
// ----------------------------------------------------------------------------
// grid_line_of_sight_top
// Grid map of wall and lit bits with Bresenham line-of-sight queries.
// ----------------------------------------------------------------------------
//  channel  direction  payload          accepted when
//  req      in         gls_pkg::req_t   req.valid & req.ready
//  rsp      out        gls_pkg::rsp_t   rsp.valid & rsp.ready
//  cfg      in         sight radius     cfg.valid & cfg.ready
//
//  A query reads one cell of the line from the map memory per cycle; its
//  single read port sets the pace. Reset clears control state and sets the
//  radius to 5; the map is undefined until written. req.ready is high in
//  idle, also while a result waits in the output register on a stalled rsp;
//  a finished query holds the input until that register frees.
// ----------------------------------------------------------------------------
module grid_line_of_sight_top #(
	parameter int MAP_WIDTH  = gls_pkg::MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = gls_pkg::MAP_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	gls_chan_if.sink   req,
	gls_chan_if.source rsp,
	gls_chan_if.sink   cfg
);

	localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = gls_pkg::XW;
	localparam int YW    = gls_pkg::YW;
	localparam int RW    = gls_pkg::RW;
	localparam int EW    = XW + 4;          // Bresenham error term, signed
	localparam int SW    = 2 * XW + 1;      // squared distance sum

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_CELL = 2'd1;
	localparam logic [1:0] KIND_TGT  = 2'd2;

	logic [1:0]           state_q;
	gls_pkg::radius_t     radius_q;
	logic [XW-1:0]        px_q, tx_q, dx_q;
	logic [YW-1:0]        py_q, ty_q, dy_q;
	logic                 sx_q, sy_q, dark_q, blocked_q;
	logic signed [EW-1:0] err_q;
	logic [2*XW-1:0]      sqx_q, sqy_q;
	logic [2*RW-1:0]      rad2_q;
	logic [1:0]           kind_s1;
	logic                 onmap_s1;
	logic [1:0]           rd_s1;            // {wall, lit}
	logic [1:0]           mem [DEPTH];
	gls_pkg::rsp_t        res_q, rsp_q;
	logic                 rsp_valid_q;

	logic                 req_acc, is_write, wr_onmap, mem_we, at_target, rd_en;
	logic                 rd_onmap, step_x, step_y, out_load, in_radius;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic [XW-1:0]        rd_x, dx_in;
	logic [YW-1:0]        rd_y, dy_in;
	logic signed [EW-1:0] e2, err_nxt;
	logic [SW-1:0]        dist2;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_acc   = req.valid && req.ready;
	assign is_write  = (req.data.func == gls_pkg::FUNC_WRITE);

	assign wr_onmap = (int'(req.data.cell_x) < MAP_WIDTH) &&
		(int'(req.data.cell_y) < MAP_HEIGHT);
	assign mem_we   = req_acc && is_write && wr_onmap;
	assign wr_addr  = AW'(int'(req.data.cell_y) * MAP_WIDTH + int'(req.data.cell_x));

	assign dx_in = (req.data.from_x > req.data.to_x) ? req.data.from_x - req.data.to_x
		: req.data.to_x - req.data.from_x;
	assign dy_in = (req.data.from_y > req.data.to_y) ? req.data.from_y - req.data.to_y
		: req.data.to_y - req.data.from_y;

	// walk: read the current cell, or the target once the line reaches it
	assign at_target = (px_q == tx_q) && (py_q == ty_q);
	assign rd_en     = (state_q == ST_WALK);
	assign rd_x      = at_target ? tx_q : px_q;
	assign rd_y      = at_target ? ty_q : py_q;
	assign rd_onmap  = (int'(rd_x) < MAP_WIDTH) && (int'(rd_y) < MAP_HEIGHT);
	assign rd_addr   = AW'(int'(rd_y) * MAP_WIDTH + int'(rd_x));

	assign e2      = err_q <<< 1;
	assign step_x  = e2 > -$signed({{(EW-YW){1'b0}}, dy_q});
	assign step_y  = e2 < $signed({{(EW-XW){1'b0}}, dx_q});
	assign err_nxt = err_q
		- (step_x ? $signed({{(EW-YW){1'b0}}, dy_q}) : EW'(0))
		+ (step_y ? $signed({{(EW-XW){1'b0}}, dx_q}) : EW'(0));

	assign dist2     = SW'(sqx_q) + SW'(sqy_q);
	assign in_radius = dist2 <= SW'(rad2_q);

	assign out_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// map memory, one synchronous read port and one write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= {req.data.cell_wall, req.data.cell_lit};
		end
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// squares of the distances, registered ahead of the compare
	always_ff @(posedge clk) begin
		sqx_q  <= {{XW{1'b0}}, dx_q} * {{XW{1'b0}}, dx_q};
		sqy_q  <= {{(2*XW-YW){1'b0}}, dy_q} * {{(2*XW-YW){1'b0}}, dy_q};
		rad2_q <= {{RW{1'b0}}, radius_q} * {{RW{1'b0}}, radius_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= gls_pkg::RADIUS_RST;
		end else if (cfg.valid && cfg.ready) begin
			radius_q <= cfg.data;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			px_q   <= req.data.from_x;
			py_q   <= req.data.from_y;
			tx_q   <= req.data.to_x;
			ty_q   <= req.data.to_y;
			dx_q   <= dx_in;
			dy_q   <= dy_in;
			sx_q   <= req.data.from_x < req.data.to_x;
			sy_q   <= req.data.from_y < req.data.to_y;
			dark_q <= req.data.darksight;
			err_q  <= $signed({{(EW-XW){1'b0}}, dx_in}) - $signed({{(EW-YW){1'b0}}, dy_in});
		end else if (rd_en && !at_target) begin
			err_q <= err_nxt;
			if (step_x) begin
				px_q <= sx_q ? px_q + XW'(1) : px_q - XW'(1);
			end
			if (step_y) begin
				py_q <= sy_q ? py_q + YW'(1) : py_q - YW'(1);
			end
		end
		if (rd_en) begin
			onmap_s1 <= rd_onmap;
		end
		if (state_q == ST_LAST) begin
			res_q.line_clear    <= !blocked_q;
			res_q.within_radius <= in_radius;
			res_q.visible       <= !blocked_q && ((onmap_s1 && rd_s1[0]) || dark_q || in_radius);
		end
		if (out_load) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_s1     <= KIND_NONE;
			blocked_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!rd_en) begin
				kind_s1 <= KIND_NONE;
			end else if (at_target) begin
				kind_s1 <= KIND_TGT;
			end else begin
				kind_s1 <= KIND_CELL;
			end

			if (req_acc) begin
				blocked_q <= 1'b0;
			end else if (kind_s1 == KIND_CELL && onmap_s1 && rd_s1[1]) begin
				blocked_q <= 1'b1;
			end

			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && !is_write) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (at_target) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

`ifndef SYNTHESIS
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_IDLE)
		else $error("map write outside idle");

	a_last_target: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LAST |-> kind_s1 == KIND_TGT)
		else $error("target read missing at end of walk");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside done");

	a_walk_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && is_write) |=> state_q == ST_IDLE)
		else $error("cell write started a walk");
`endif

endmodule
